### hdl/polynomial_evaluator_unit_macros.svh
// ----------------------------------------------------------------------------
// Polynomial evaluator assertion macros
// Shared concurrent assertion forms for the polynomial evaluator.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_EVALUATOR_UNIT_MACROS_SVH
`define POLYNOMIAL_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PEU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define PEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/polyev_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial evaluator package
// Register indexes, widths and Q16.16 limits for the polynomial evaluator.
// ----------------------------------------------------------------------------
package polyev_pkg;

   // data widths
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int DEG_W     = 3;
   localparam int CSR_IDX_W = 4;
   localparam int NUM_COEFS = 7;
   localparam int COEF_IDX_W = 3;

   typedef logic signed [DATA_W-1:0] q16_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLY_DEGREE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_6      = 4'd7;

   // saturation limits
   localparam q16_type S32_MAX = 32'sh7FFF_FFFF;
   localparam q16_type S32_MIN = 32'sh8000_0000;

endpackage

### hdl/polynomial_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Polynomial evaluator unit
// Pipelined power-series evaluator, c0 + c1*x + ... + cd*x^d in Q16.16.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   req     | req_valid/ready, req_x_value  | in
//   rsp     | rsp_valid/ready, poly, ovf    | out
//   csr     | csr_valid/ready, index, wdata | in
//
// One sample enters per cycle when not stalled; each term has one multiply
// stage and one shift/saturate/accumulate stage. Each stage has its own
// valid bit and takes data when empty or when the stage after it moves, so
// a stalled result holds while bubbles close up. Synchronous reset clears
// valid bits, degree and coefficients to zero. The csr port is always
// ready; the user must make writes only while the unit is idle, unchecked.
// ----------------------------------------------------------------------------
`include "polynomial_evaluator_unit_macros.svh"

module polynomial_evaluator_unit import polyev_pkg::*; #(
   parameter int MAX_TERMS = 7,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // sample input
   input  logic                 req_valid,
   output logic                 req_ready,
   input  q16_type              req_x_value,
   // result output
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output q16_type              rsp_poly_value,
   output logic                 rsp_overflow,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  q16_type              csr_wdata
);

   localparam int NT     = MAX_TERMS - 1;
   localparam int NT_A   = (NT > 0) ? NT : 1;
   localparam int SH_W   = PROD_W - FRAC_BITS;
   localparam int ACC_W  = SH_W + 3;
   localparam logic [DEG_W-1:0] LAST_TERM = DEG_W'(NT);
   localparam prod_type P_MAX = PROD_W'(S32_MAX);
   localparam prod_type P_MIN = PROD_W'(S32_MIN);
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(S32_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(S32_MIN);

   // configuration registers
   logic [DEG_W-1:0] poly_degree_ff;
   q16_type          coef_ff [0:NUM_COEFS-1];
   logic [DEG_W-1:0] deg_eff;

   // accumulate stages (index 0 is the input stage)
   logic                    bv_ff   [0:NT];
   q16_type                 bx_ff   [0:NT];
   q16_type                 bp_ff   [0:NT];
   logic signed [ACC_W-1:0] bacc_ff [0:NT];
   logic                    bovf_ff [0:NT];
   logic                    bready  [0:NT];
   logic                    bdown   [0:NT];

   // multiply stages
   logic                    av_ff   [1:NT_A];
   q16_type                 ax_ff   [1:NT_A];
   prod_type                at_ff   [1:NT_A];
   prod_type                ap_ff   [1:NT_A];
   logic signed [ACC_W-1:0] aacc_ff [1:NT_A];
   logic                    aovf_ff [1:NT_A];
   logic                    aready  [1:NT_A];

   // output register
   logic    rsp_valid_ff;
   q16_type rsp_poly_ff;
   logic    rsp_ovf_ff;
   logic    out_rdy;
   logic    fin_sat_in;
   q16_type fin_val_in;

   // configuration write port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_degree_ff <= '0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index) inside
            CSR_POLY_DEGREE: poly_degree_ff <= csr_wdata[DEG_W-1:0];
            [CSR_COEF_0:CSR_COEF_6]:
               coef_ff[COEF_IDX_W'(csr_index - CSR_COEF_0)] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp degree to the number of term stages
   assign deg_eff = (poly_degree_ff > LAST_TERM) ? LAST_TERM : poly_degree_ff;

   // input stage
   assign out_rdy   = !rsp_valid_ff || rsp_ready;
   assign bdown[NT] = out_rdy;
   assign req_ready = bready[0];

   always_comb begin
      for (int k = 0; k <= NT; k++) begin
         bready[k] = !bv_ff[k] || bdown[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff[0] <= 1'b0;
      end else if (bready[0]) begin
         bv_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (bready[0]) begin
         bx_ff[0]   <= req_x_value;
         bp_ff[0]   <= req_x_value;
         bacc_ff[0] <= ACC_W'(coef_ff[0]);
         bovf_ff[0] <= 1'b0;
      end
   end

   // one multiply stage and one accumulate stage per term
   for (genvar k = 1; k <= NT; k++) begin : g_term
      prod_type                t_sh_in;
      prod_type                p_sh_in;
      logic                    p_sat_in;
      logic signed [ACC_W-1:0] acc_in;
      q16_type                 p_in;
      logic                    ovf_in;

      assign bdown[k-1] = aready[k];
      assign aready[k]  = !av_ff[k] || bready[k];

      // term product and next power product, both from registered operands
      always_ff @(posedge clock) begin
         if (reset) begin
            av_ff[k] <= 1'b0;
         end else if (aready[k]) begin
            av_ff[k] <= bv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (aready[k]) begin
            at_ff[k]   <= coef_ff[k] * bp_ff[k-1];
            ap_ff[k]   <= bp_ff[k-1] * bx_ff[k-1];
            ax_ff[k]   <= bx_ff[k-1];
            aacc_ff[k] <= bacc_ff[k-1];
            aovf_ff[k] <= bovf_ff[k-1];
         end
      end

      // scale, accumulate used term, saturate the next power
      always_comb begin
         t_sh_in  = at_ff[k] >>> FRAC_BITS;
         p_sh_in  = ap_ff[k] >>> FRAC_BITS;
         p_sat_in = (p_sh_in > P_MAX) || (p_sh_in < P_MIN);
         if (DEG_W'(k) <= deg_eff) begin
            acc_in = aacc_ff[k] + ACC_W'($signed(t_sh_in[SH_W-1:0]));
         end else begin
            acc_in = aacc_ff[k];
         end
         if (p_sh_in > P_MAX) begin
            p_in = S32_MAX;
         end else if (p_sh_in < P_MIN) begin
            p_in = S32_MIN;
         end else begin
            p_in = p_sh_in[DATA_W-1:0];
         end
         ovf_in = aovf_ff[k] || (p_sat_in && (DEG_W'(k) < deg_eff));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            bv_ff[k] <= 1'b0;
         end else if (bready[k]) begin
            bv_ff[k] <= av_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (bready[k]) begin
            bx_ff[k]   <= ax_ff[k];
            bp_ff[k]   <= p_in;
            bacc_ff[k] <= acc_in;
            bovf_ff[k] <= ovf_in;
         end
      end
   end

   // final saturation into the output register
   always_comb begin
      fin_sat_in = (bacc_ff[NT] > ACC_MAX) || (bacc_ff[NT] < ACC_MIN);
      if (bacc_ff[NT] > ACC_MAX) begin
         fin_val_in = S32_MAX;
      end else if (bacc_ff[NT] < ACC_MIN) begin
         fin_val_in = S32_MIN;
      end else begin
         fin_val_in = bacc_ff[NT][DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= bv_ff[NT];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_poly_ff <= fin_val_in;
         rsp_ovf_ff  <= bovf_ff[NT] || fin_sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_poly_value = rsp_poly_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // checks on pipeline movement and the overflow flag
   `PEU_ASSERT_NEXT(a_in_transfer_lands, clock, reset,
      req_valid && req_ready, bv_ff[0], "accepted sample missing from input stage")
   `PEU_ASSERT_NEXT(a_last_stage_holds, clock, reset,
      bv_ff[NT] && !out_rdy, bv_ff[NT], "last stage dropped while output stalled")
   `PEU_ASSERT_NEXT(a_out_loads, clock, reset,
      bv_ff[NT] && out_rdy, rsp_valid_ff, "last stage moved but no result shown")
   `PEU_ASSERT_SAME(a_low_degree_ovf, clock, reset,
      rsp_valid_ff && (deg_eff <= 3'd1) && (rsp_poly_ff != S32_MAX) && (rsp_poly_ff != S32_MIN),
      !rsp_ovf_ff, "overflow flagged without any saturation")

endmodule
